// File: sv/bsed_pkg.sv
// Shared types and constants of the binary Sobel edge detector.
// Used by binary_sobel_edge_detector; depends on nothing else.
package bsed_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_FRAME_WIDTH    = 2'd0;
  localparam cfg_index_t REG_FRAME_HEIGHT   = 2'd1;
  localparam cfg_index_t REG_BW_THRESHOLD   = 2'd2;
  localparam cfg_index_t REG_EDGE_THRESHOLD = 2'd3;

  localparam int CFG_DATA_W = 12;
  localparam int LIM_W      = 24;   // holds T*T+T for a 12-bit threshold
  localparam int MAG_W      = 25;   // holds 765*765*32

  // Register values after reset.
  localparam logic [11:0]      RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0]      RST_FRAME_HEIGHT = 12'd480;
  localparam logic [7:0]       RST_BW_THRESHOLD = 8'd124;
  localparam logic [LIM_W-1:0] RST_EDGE_LIMIT   = 24'd16512;   // 128*128+128

  localparam logic [7:0] GRAY_WHITE = 8'd255;
  localparam logic [7:0] GRAY_BLACK = 8'd0;

  // Gradients are summed over three equal channels of 255: scale 765 squared.
  localparam logic [19:0] MAG_SCALE = 20'd585225;

  // Sobel kernels indexed [column][row], column 0 oldest, row 0 top.
  typedef logic signed [2:0] coef_t;
  localparam coef_t KX [3][3] = '{'{-3'sd1, 3'sd0, 3'sd1},
                                  '{-3'sd2, 3'sd0, 3'sd2},
                                  '{-3'sd1, 3'sd0, 3'sd1}};
  localparam coef_t KY [3][3] = '{'{ 3'sd1,  3'sd2,  3'sd1},
                                  '{ 3'sd0,  3'sd0,  3'sd0},
                                  '{-3'sd1, -3'sd2, -3'sd1}};

  // Output queue depth.
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  // One queued result.
  typedef struct packed {
    logic        frame_done;
    logic        is_edge;
    logic [7:0]  gray_value;
    logic [11:0] out_row;
    logic [10:0] out_col;
  } result_t;

endpackage

// File: sv/bsed_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the line stores of the edge detector.
module bsed_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/binary_sobel_edge_detector.sv
// Binary Sobel edge detector: binarize, two line-store RAMs, 3x3 window, threshold.
// Depends on bsed_pkg and bsed_ram.
//
//   Channel  Direction  Payload                                        Request when
//   s_axis   in         tdata: red, green, blue                        tvalid & tready
//   m_axis   out        tdata: out_col, out_row, gray_value;           tvalid & tready
//                       tuser: is_edge; tlast: frame_done
//   cfg      in         cfg_index, cfg_data                            cfg_en
//
// One pixel is taken per clock while s_axis_tready is high; its result, if any, passes
// through the s1 and s2 registers into the output queue and is offered from there.
// The line-store RAMs keep up with this rate: one read in the accept cycle and one
// write back in the next, on separate read and write ports.
// Results wait in an 8-entry queue; the input stalls only while the queue and
// the two pipeline stages together could overflow it.
// Reset is immediate: a fill mark makes never-written line-store entries read as zero.
module binary_sobel_edge_detector #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // Pixel requests in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Result requests out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_col [10:0], out_row [22:11], gray_value [30:23]
  output logic        m_axis_tuser,   // is_edge [0]
  output logic        m_axis_tlast,
  // Configuration writes.
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (FW > 12) ? FW : 12;

  // Configuration.
  logic [11:0]               frame_width;
  logic [11:0]               frame_height;
  logic [7:0]                bw_threshold;
  logic [bsed_pkg::LIM_W-1:0] edge_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bsed_pkg::RST_FRAME_WIDTH;
      frame_height <= bsed_pkg::RST_FRAME_HEIGHT;
      bw_threshold <= bsed_pkg::RST_BW_THRESHOLD;
      edge_limit   <= bsed_pkg::RST_EDGE_LIMIT;
    end else if (cfg_en) begin
      unique case (cfg_index)
        bsed_pkg::REG_FRAME_WIDTH:    frame_width  <= cfg_data;
        bsed_pkg::REG_FRAME_HEIGHT:   frame_height <= cfg_data;
        bsed_pkg::REG_BW_THRESHOLD:   bw_threshold <= cfg_data[7:0];
        bsed_pkg::REG_EDGE_THRESHOLD: begin
          // Rounded magnitude > T is the same as squared magnitude > T*T+T.
          edge_limit <= bsed_pkg::LIM_W'(cfg_data) * bsed_pkg::LIM_W'(cfg_data)
                        + bsed_pkg::LIM_W'(cfg_data);
        end
      endcase
    end
  end

  // Accept stage: counters, binarization, line-store read.
  logic [CW-1:0]  col;
  logic [CW-1:0]  col_next;
  logic [11:0]    row;
  logic [11:0]    row_next;
  logic [FW-1:0]  fill;
  logic [WW-1:0]  w_cfg;
  logic [WW-1:0]  w_eff;
  logic [11:0]    h_eff;
  logic           end_line;
  logic           end_frame;
  logic [9:0]     chan_sum;
  logic           new_bit;
  logic           accept;
  logic [CW-1:0]  oc_full;
  logic [bsed_pkg::QAW:0] q_count;
  logic [bsed_pkg::QAW+2:0] committed;

  logic           s1_valid, s1_ok, s1_nb, s1_emit, s1_border, s1_last;
  logic [CW-1:0]  s1_addr;
  logic [10:0]    s1_col;
  logic [11:0]    s1_row;
  logic           s2_valid;

  assign committed = (bsed_pkg::QAW+3)'(q_count) + (bsed_pkg::QAW+3)'(s1_valid)
                     + (bsed_pkg::QAW+3)'(s2_valid);
  assign s_axis_tready = committed < (bsed_pkg::QAW+3)'(bsed_pkg::QDEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    w_cfg = WW'(frame_width);
    if (w_cfg < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_cfg > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    h_eff     = (frame_height < 12'd3) ? 12'd3 : frame_height;
    end_line  = WW'(col) >= (w_eff - WW'(1));
    end_frame = end_line && (row >= (h_eff - 12'd1));
    col_next  = end_line ? '0 : col + CW'(1);
    row_next  = end_frame ? 12'd0 : (end_line ? row + 12'd1 : row);
    chan_sum  = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                + 10'(s_axis_tdata[23:16]);
    // sum/3 > thr is the same as sum > 3*thr+2.
    new_bit   = chan_sum > (10'(bw_threshold) * 10'd3 + 10'd2);
    oc_full   = col - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      fill     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
        // Columns are written from zero upward, so written entries form a prefix.
        if (FW'(col) >= fill) begin
          fill <= FW'(col) + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr   <= col;
      s1_ok     <= FW'(col) < fill;
      s1_nb     <= new_bit;
      s1_emit   <= (col != '0) && (row != 12'd0);
      s1_border <= (col == CW'(1)) || (row == 12'd1);
      s1_last   <= end_frame;
      s1_col    <= 11'(oc_full);
      s1_row    <= row - 12'd1;
    end
  end

  // Line stores: upper holds row r-2, middle row r-1. Read on accept, write back next cycle.
  logic up_rdata, mid_rdata;
  logic ub, mb;

  assign ub = s1_ok && up_rdata;
  assign mb = s1_ok && mid_rdata;

  bsed_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (mb),
    .re    (accept),
    .raddr (col),
    .rdata (up_rdata)
  );

  bsed_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (s1_nb),
    .re    (accept),
    .raddr (col),
    .rdata (mid_rdata)
  );

  // Window: bit 3*column+row, column 0 oldest, row 0 top. New column enters at the top bits.
  logic [8:0]  window;
  logic        s2_emit, s2_border, s2_last;
  logic [10:0] s2_col;
  logic [11:0] s2_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        window <= {s1_nb, mb, ub, window[8:3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_emit   <= s1_emit;
    s2_border <= s1_border;
    s2_last   <= s1_last;
    s2_col    <= s1_col;
    s2_row    <= s1_row;
  end

  // Sobel and threshold.
  logic signed [3:0]           sx, sy;
  logic [5:0]                  grad_sq;
  logic [bsed_pkg::MAG_W-1:0]  mag;
  logic                        edge_hit;
  bsed_pkg::result_t           res;

  always_comb begin
    sx = '0;
    sy = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (window[3*i+j]) begin
          sx = sx + 4'(bsed_pkg::KX[i][j]);
          sy = sy + 4'(bsed_pkg::KY[i][j]);
        end
      end
    end
    grad_sq  = 6'(sx * sx) + 6'(sy * sy);
    mag      = bsed_pkg::MAG_W'(grad_sq) * bsed_pkg::MAG_W'(bsed_pkg::MAG_SCALE);
    edge_hit = !s2_border && (mag > bsed_pkg::MAG_W'(edge_limit));
    res.out_col    = s2_col;
    res.out_row    = s2_row;
    res.is_edge    = edge_hit;
    res.gray_value = (s2_border || edge_hit) ? bsed_pkg::GRAY_BLACK : bsed_pkg::GRAY_WHITE;
    res.frame_done = s2_last;
  end

  // Output queue.
  bsed_pkg::result_t        q_mem [bsed_pkg::QDEPTH];
  logic [bsed_pkg::QAW-1:0] q_wr, q_rd;
  logic                     q_push, q_pop;
  bsed_pkg::result_t        q_head;

  assign q_push = s2_valid && s2_emit;
  assign q_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wr <= q_wr + bsed_pkg::QAW'(1);
      end
      if (q_pop) begin
        q_rd <= q_rd + bsed_pkg::QAW'(1);
      end
      priority if (q_push && !q_pop) begin
        q_count <= q_count + (bsed_pkg::QAW+1)'(1);
      end else if (q_pop && !q_push) begin
        q_count <= q_count - (bsed_pkg::QAW+1)'(1);
      end
    end
  end

  assign q_head        = q_mem[q_rd];
  assign m_axis_tvalid = q_count != '0;
  assign m_axis_tdata  = {1'b0, q_head.gray_value, q_head.out_row, q_head.out_col};
  assign m_axis_tuser  = q_head.is_edge;
  assign m_axis_tlast  = q_head.frame_done;

endmodule

// File: test/bsed_edge_checker.sv
`timescale 1ns / 1ps
// Result checker for the binary Sobel edge detector: follows pixel and config
// requests, predicts every output pixel and compares it with the result stream.
// Depends on bsed_pkg for the register indexes and reset values.
module bsed_edge_checker #(
  parameter int MAX_W = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // out_col [10:0], out_row [22:11], gray_value [30:23]
  input  logic        m_axis_tuser,   // is_edge [0]
  input  logic        m_axis_tlast,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [10:0] col;
    logic [11:0] row;
    logic [7:0]  gray;
    logic        is_edge;
    logic        frame_done;
  } out_pixel_t;

  // Kernels indexed [column][row], column 0 oldest, row 0 top.
  localparam int SOBEL_H [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int SOBEL_V [3][3] = '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}};
  // Three equal channels of full scale: (3 * 255) squared.
  localparam longint CHANNEL_SCALE_SQ = 585225;

  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [7:0]  bw_reg;
  logic [11:0] edge_reg;

  bit         upper_line [MAX_W];
  bit         middle_line [MAX_W];
  logic [8:0] window;
  int         col_cnt;
  int         row_cnt;

  out_pixel_t edge_pixels_due [$];

  task automatic predict_output(input logic [23:0] px);
    int         w;
    int         h;
    int         sum;
    int         idx;
    int         sx;
    int         sy;
    bit         fresh;
    bit         above;
    bit         mid;
    bit         end_line;
    bit         end_frame;
    longint     mag;
    longint     lim;
    out_pixel_t o;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    h = height_reg;
    if (h < 3) h = 3;
    sum = int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16]);
    fresh = (sum / 3) > int'(bw_reg);
    idx = col_cnt % MAX_W;
    above = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx] = mid;
    middle_line[idx] = fresh;
    window = {fresh, mid, above, window[8:3]};
    end_line = col_cnt >= w - 1;
    end_frame = end_line && (row_cnt >= h - 1);
    if (col_cnt >= 1 && row_cnt >= 1) begin
      o.col = 11'(col_cnt - 1);
      o.row = 12'(row_cnt - 1);
      o.gray = 8'd0;
      o.is_edge = 1'b0;
      o.frame_done = end_frame;
      // Outputs on the top row or left column are border pixels and stay black.
      if (col_cnt >= 2 && row_cnt >= 2) begin
        sx = 0;
        sy = 0;
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) begin
            if (window[3*c+r]) begin
              sx += SOBEL_H[c][r];
              sy += SOBEL_V[c][r];
            end
          end
        end
        mag = CHANNEL_SCALE_SQ * longint'(sx * sx + sy * sy);
        lim = longint'(edge_reg) * longint'(edge_reg) + longint'(edge_reg);
        o.is_edge = mag > lim;
        o.gray = o.is_edge ? 8'd0 : 8'd255;
      end
      edge_pixels_due.push_back(o);
    end
    if (end_line) begin
      col_cnt = 0;
      row_cnt = end_frame ? 0 : ((row_cnt + 1) & 12'hFFF);
    end else begin
      col_cnt++;
    end
  endtask

  function automatic void compare_field(input string name, input logic [11:0] want,
                                        input logic [11:0] got);
    if (got !== want) begin
      $error("%s expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    out_pixel_t want;
    if (edge_pixels_due.size() == 0) begin
      $error("out_col %0d out_row %0d arrived with no pixel waiting for it",
             m_axis_tdata[10:0], m_axis_tdata[22:11]);
      mismatches++;
      return;
    end
    want = edge_pixels_due.pop_front();
    compare_field("out_col", 12'(want.col), 12'(m_axis_tdata[10:0]));
    compare_field("out_row", want.row, m_axis_tdata[22:11]);
    compare_field("gray_value", 12'(want.gray), 12'(m_axis_tdata[30:23]));
    compare_field("is_edge", 12'(want.is_edge), 12'(m_axis_tuser));
    compare_field("frame_done", 12'(want.frame_done), 12'(m_axis_tlast));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = bsed_pkg::RST_FRAME_WIDTH;
      height_reg = bsed_pkg::RST_FRAME_HEIGHT;
      bw_reg = bsed_pkg::RST_BW_THRESHOLD;
      edge_reg = 12'd128;
      for (int i = 0; i < MAX_W; i++) begin
        upper_line[i] = 1'b0;
        middle_line[i] = 1'b0;
      end
      window = '0;
      col_cnt = 0;
      row_cnt = 0;
      edge_pixels_due.delete();
      mismatches = 0;
    end else begin
      // Results are checked before this edge's pixel adds its own prediction.
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_en) begin
        case (cfg_index)
          bsed_pkg::REG_FRAME_WIDTH:    width_reg = cfg_data;
          bsed_pkg::REG_FRAME_HEIGHT:   height_reg = cfg_data;
          bsed_pkg::REG_BW_THRESHOLD:   bw_reg = cfg_data[7:0];
          bsed_pkg::REG_EDGE_THRESHOLD: edge_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_output(s_axis_tdata);
    end
    outstanding <= edge_pixels_due.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the binary Sobel edge detector testbench: clock, reset, pixel and
// config stimulus, result sink and verdict. Depends on bsed_pkg, the block and bsed_edge_checker.
module testbench;

  localparam int TOTAL_PIXELS = 950;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  // Two 3x3 frames, packed {blue, green, red}. The first has a dark left side, a
  // light right side and both sides of the binarize threshold (sums 374 and 375);
  // the second is flat white.
  localparam logic [23:0] DIRECTED [18] = '{
    24'h000000, 24'h7D7D7C, 24'hFFFFFF,
    24'h0000FF, 24'h00FF00, 24'h7D7D7D,
    24'hFF0000, 24'h00FFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_en = 1'b0;
  logic [1:0]  cfg_index = bsed_pkg::REG_FRAME_WIDTH;
  logic [11:0] cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int          pixels_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  bw_now = bsed_pkg::RST_BW_THRESHOLD;
  wire         calm = (pixels_sent >= 500) && (pixels_sent < 650);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  binary_sobel_edge_detector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bsed_edge_checker edge_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_en        (cfg_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic logic [23:0] random_pixel();
    logic [7:0] v;
    int         lvl;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return {v, v, v};
      end
      1: begin
        // Gray level right at the binarize threshold.
        lvl = int'(bw_now) + $urandom_range(0, 2);
        if (lvl > 255) lvl = 255;
        v = lvl[7:0];
        return {v, v, v};
      end
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [23:0] px);
    while (!calm && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
  endtask

  // The block is idle once every predicted result is out and the pipeline has drained.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [11:0] width_val;
    logic [11:0] height_val;
    logic [11:0] edge_val;
    int          count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero width and height act as a 3x3 frame; the thresholds keep their reset values.
    write_reg(bsed_pkg::REG_FRAME_WIDTH, 12'd0);
    write_reg(bsed_pkg::REG_FRAME_HEIGHT, 12'd0);
    foreach (DIRECTED[i]) send_pixel(DIRECTED[i]);
    wait_idle();

    // An oversized width clamps to the line-store size; the narrow width of the
    // next phase then ends this line in the middle.
    write_reg(bsed_pkg::REG_FRAME_WIDTH, 12'd4095);
    write_reg(bsed_pkg::REG_FRAME_HEIGHT, 12'd4095);
    repeat (40) send_pixel(random_pixel());
    wait_idle();

    while (pixels_sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 7))
        0:       width_val = $urandom_range(0, 2);
        1:       width_val = $urandom_range(11, 40);
        default: width_val = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 7))
        0:       height_val = $urandom_range(0, 2);
        1:       height_val = 12'd4095;
        default: height_val = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 5))
        0:       bw_now = 8'd0;
        1:       bw_now = 8'd255;
        2:       bw_now = bsed_pkg::RST_BW_THRESHOLD;
        default: bw_now = $urandom_range(0, 255);
      endcase
      // A unit gradient sum scales to 765, so 764 and 765 sit on either side.
      case ($urandom_range(0, 6))
        0:       edge_val = 12'd0;
        1:       edge_val = 12'd764;
        2:       edge_val = 12'd765;
        3:       edge_val = 12'd4095;
        default: edge_val = $urandom_range(0, 3000);
      endcase
      write_reg(bsed_pkg::REG_FRAME_WIDTH, width_val);
      write_reg(bsed_pkg::REG_FRAME_HEIGHT, height_val);
      write_reg(bsed_pkg::REG_BW_THRESHOLD, {4'd0, bw_now});
      write_reg(bsed_pkg::REG_EDGE_THRESHOLD, edge_val);
      count = $urandom_range(15, 90);
      repeat (count) send_pixel(random_pixel());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result sink: random back-pressure, plus one long hold that fills the block.
  initial begin : result_sink
    int held;
    bit hold_done;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!hold_done && pixels_sent >= 300) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
